// ===== rtl/sd_spi_command_transaction_macros.svh =====
// Assertion macros used by the command engine checker.
`ifndef SD_SPI_COMMAND_TRANSACTION_MACROS_SVH
`define SD_SPI_COMMAND_TRANSACTION_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SDSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SDSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdsc_pkg.sv =====
// Types and constants shared by the SD SPI command engine.
package sdsc_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_READY_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT    = 1'b1;

  localparam logic [15:0] READY_TIMEOUT_RST = 16'd500;
  localparam logic [7:0]  POLL_LIMIT_RST    = 8'd10;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [7:0] CMD55_BYTE  = 8'h77;
  localparam logic [7:0] CMD0_BYTE   = 8'h40;
  localparam logic [7:0] CMD8_BYTE   = 8'h48;
  localparam logic [7:0] CMD12_BYTE  = 8'h4C;
  localparam logic [7:0] CRC_CMD0    = 8'h95;
  localparam logic [7:0] CRC_CMD8    = 8'h87;
  localparam logic [7:0] CRC_OTHER   = 8'h01;

  localparam logic [2:0] LAST_PKT_IDX = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DUMMY,
    PH_READY,
    PH_SEND,
    PH_STUFF,
    PH_POLL
  } phase_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  command_byte;
    logic [31:0] argument;
    logic [7:0]  miso_byte;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  mosi_byte;
    logic        card_select;
    logic [7:0]  response;
  } res_item_t;

  typedef struct packed {
    logic      valid;
    res_item_t item;
  } step_res_t;

endpackage

// ===== rtl/sdsc_in_if.sv =====
// Input channel: valid/ready with the command item payload.
interface sdsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  command_byte;
  logic [31:0] argument;
  logic [7:0]  miso_byte;

  modport source (output valid, cmd, command_byte, argument, miso_byte, input ready);
  modport sink   (input valid, cmd, command_byte, argument, miso_byte, output ready);
endinterface

// ===== rtl/sdsc_out_if.sv =====
// Result channel: valid/ready with the result item payload.
interface sdsc_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] mosi_byte;
  logic       card_select;
  logic [7:0] response;

  modport source (output valid, out_kind, mosi_byte, card_select, response, input ready);
  modport sink   (input valid, out_kind, mosi_byte, card_select, response, output ready);
endinterface

// ===== rtl/sdsc_in_stage.sv =====
// Input register stage: holds one accepted item for the step logic.
module sdsc_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  sdsc_in_if.sink            in_ch,
  input  logic               adv,
  output logic               item_vld,
  output sdsc_pkg::in_item_t item
);

  logic               vld_r, vld_nxt;
  sdsc_pkg::in_item_t item_r;
  logic               take;

  assign in_ch.ready = !vld_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = 1'b0;
    end
    if (take) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{cmd: in_ch.cmd, command_byte: in_ch.command_byte,
                  argument: in_ch.argument, miso_byte: in_ch.miso_byte};
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== rtl/sdsc_step.sv =====
// Command sequencer: state registers, config registers and per-item step logic.
module sdsc_step (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               fire,
  input  sdsc_pkg::in_item_t                 item,
  input  logic                               cfg_we,
  input  logic [sdsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sdsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output sdsc_pkg::step_res_t                res
);

  sdsc_pkg::phase_t phase_r, phase_nxt;
  logic [6:0]  active_r, active_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic        prefix_r, prefix_nxt;
  logic [2:0]  bi_r, bi_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [7:0]  polls_r, polls_nxt;
  logic        sel_r, sel_nxt;
  logic [15:0] timeout_r;
  logic [7:0]  limit_r;

  logic [7:0]  cur_cmd;
  logic [31:0] cur_arg;
  logic [7:0]  rx;
  logic        is_byte;
  logic [2:0]  bi_inc;
  logic [7:0]  poll_dec;
  logic [7:0]  limit_eff;
  logic        fin;
  logic [7:0]  fin_res;
  logic        relaunch;

  function automatic logic [7:0] pkt_byte(input logic [2:0] idx, input logic [7:0] c,
                                          input logic [31:0] a);
    logic [7:0] b;
    case (idx)
      3'd0: b = c;
      3'd1: b = a[31:24];
      3'd2: b = a[23:16];
      3'd3: b = a[15:8];
      3'd4: b = a[7:0];
      default: begin
        if (c == sdsc_pkg::CMD0_BYTE) begin
          b = sdsc_pkg::CRC_CMD0;
        end else if (c == sdsc_pkg::CMD8_BYTE) begin
          b = sdsc_pkg::CRC_CMD8;
        end else begin
          b = sdsc_pkg::CRC_OTHER;
        end
      end
    endcase
    return b;
  endfunction

  assign cur_cmd   = prefix_r ? sdsc_pkg::CMD55_BYTE : {1'b0, active_r};
  assign cur_arg   = prefix_r ? 32'd0 : arg_r;
  assign rx        = item.miso_byte;
  assign is_byte   = fire && (item.cmd == sdsc_pkg::CMD_BYTE);
  assign bi_inc    = bi_r + 3'd1;
  assign poll_dec  = (polls_r != 8'd0) ? polls_r - 8'd1 : 8'd0;
  assign limit_eff = (limit_r != 8'd0) ? limit_r : 8'd1;

  // end of one command attempt: ready timeout, R1 settled or poll limit reached
  assign fin = is_byte &&
               (((phase_r == sdsc_pkg::PH_READY) && (rx != sdsc_pkg::BYTE_IDLE) &&
                 (ticks_r == 16'd0)) ||
                ((phase_r == sdsc_pkg::PH_POLL) && !(rx[7] && (poll_dec != 8'd0))));
  assign fin_res  = (phase_r == sdsc_pkg::PH_READY) ? sdsc_pkg::BYTE_IDLE : rx;
  // CMD55 answered with 0 or 1: go on with the real command
  assign relaunch = fin && prefix_r && (fin_res[7:1] == 7'd0);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      case (item.cmd)
        sdsc_pkg::CMD_START: begin
          if (phase_r == sdsc_pkg::PH_IDLE) begin
            phase_nxt = sdsc_pkg::PH_DUMMY;
          end
        end
        sdsc_pkg::CMD_BYTE: begin
          case (phase_r)
            sdsc_pkg::PH_DUMMY: phase_nxt = sdsc_pkg::PH_READY;
            sdsc_pkg::PH_READY: begin
              if (rx == sdsc_pkg::BYTE_IDLE) begin
                phase_nxt = sdsc_pkg::PH_SEND;
              end else if (fin) begin
                phase_nxt = relaunch ? sdsc_pkg::PH_DUMMY : sdsc_pkg::PH_IDLE;
              end
            end
            sdsc_pkg::PH_SEND: begin
              if (bi_inc > sdsc_pkg::LAST_PKT_IDX) begin
                phase_nxt = (cur_cmd == sdsc_pkg::CMD12_BYTE) ? sdsc_pkg::PH_STUFF
                                                              : sdsc_pkg::PH_POLL;
              end
            end
            sdsc_pkg::PH_STUFF: phase_nxt = sdsc_pkg::PH_POLL;
            sdsc_pkg::PH_POLL: begin
              if (fin) begin
                phase_nxt = relaunch ? sdsc_pkg::PH_DUMMY : sdsc_pkg::PH_IDLE;
              end
            end
            default: phase_nxt = phase_r;
          endcase
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    active_nxt = active_r;
    arg_nxt    = arg_r;
    prefix_nxt = prefix_r;
    bi_nxt     = bi_r;
    ticks_nxt  = ticks_r;
    polls_nxt  = polls_r;
    sel_nxt    = sel_r;
    res.valid            = 1'b0;
    res.item.out_kind    = 1'b0;
    res.item.mosi_byte   = sdsc_pkg::BYTE_IDLE;
    res.item.response    = 8'd0;
    if (fire) begin
      case (item.cmd)
        sdsc_pkg::CMD_START: begin
          if (phase_r == sdsc_pkg::PH_IDLE) begin
            active_nxt = item.command_byte[6:0];
            prefix_nxt = item.command_byte[7];
            arg_nxt    = item.argument;
            bi_nxt     = 3'd0;
            sel_nxt    = 1'b0;
            ticks_nxt  = timeout_r;
            res.valid  = 1'b1;
          end
        end
        sdsc_pkg::CMD_TICK: begin
          if (((phase_r == sdsc_pkg::PH_DUMMY) || (phase_r == sdsc_pkg::PH_READY)) &&
              (ticks_r != 16'd0)) begin
            ticks_nxt = ticks_r - 16'd1;
          end
        end
        sdsc_pkg::CMD_BYTE: begin
          case (phase_r)
            sdsc_pkg::PH_DUMMY: res.valid = 1'b1;
            sdsc_pkg::PH_READY: begin
              if (rx == sdsc_pkg::BYTE_IDLE) begin
                bi_nxt             = 3'd0;
                res.valid          = 1'b1;
                res.item.mosi_byte = cur_cmd;
              end else if (!fin) begin
                res.valid = 1'b1;
              end
            end
            sdsc_pkg::PH_SEND: begin
              res.valid = 1'b1;
              if (bi_inc <= sdsc_pkg::LAST_PKT_IDX) begin
                bi_nxt             = bi_inc;
                res.item.mosi_byte = pkt_byte(bi_inc, cur_cmd, cur_arg);
              end else begin
                bi_nxt = 3'd0;
                if (cur_cmd != sdsc_pkg::CMD12_BYTE) begin
                  polls_nxt = limit_eff;
                end
              end
            end
            sdsc_pkg::PH_STUFF: begin
              polls_nxt = limit_eff;
              res.valid = 1'b1;
            end
            sdsc_pkg::PH_POLL: begin
              polls_nxt = poll_dec;
              if (!fin) begin
                res.valid = 1'b1;
              end
            end
            default: res.valid = 1'b0;
          endcase
        end
        default: res.valid = 1'b0;
      endcase
      if (fin) begin
        prefix_nxt = 1'b0;
        res.valid  = 1'b1;
        if (relaunch) begin
          sel_nxt   = 1'b0;
          ticks_nxt = timeout_r;
        end else begin
          bi_nxt             = 3'd0;
          res.item.out_kind  = 1'b1;
          res.item.mosi_byte = 8'd0;
          res.item.response  = fin_res;
        end
      end
    end
    res.item.card_select = sel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= sdsc_pkg::PH_IDLE;
      active_r <= '0;
      arg_r    <= '0;
      prefix_r <= 1'b0;
      bi_r     <= '0;
      ticks_r  <= '0;
      polls_r  <= '0;
      sel_r    <= 1'b1;
    end else begin
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
      arg_r    <= arg_nxt;
      prefix_r <= prefix_nxt;
      bi_r     <= bi_nxt;
      ticks_r  <= ticks_nxt;
      polls_r  <= polls_nxt;
      sel_r    <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= sdsc_pkg::READY_TIMEOUT_RST;
      limit_r   <= sdsc_pkg::POLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sdsc_pkg::REG_READY_TIMEOUT: timeout_r <= cfg_wdata;
        sdsc_pkg::REG_POLL_LIMIT:    limit_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/sdsc_out_reg.sv =====
// Result register: holds one result until the sink takes it.
module sdsc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  sdsc_pkg::step_res_t res,
  output logic                adv,
  sdsc_out_if.source          out_ch
);

  logic                vld_r, vld_nxt;
  sdsc_pkg::res_item_t item_r;

  assign adv = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      item_r <= res.item;
    end
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.out_kind    = item_r.out_kind;
  assign out_ch.mosi_byte   = item_r.mosi_byte;
  assign out_ch.card_select = item_r.card_select;
  assign out_ch.response    = item_r.response;

endmodule

// ===== rtl/sd_spi_command_transaction.sv =====
// Top level of the SD card SPI-mode command engine.
// An item waits in the input register until stepped; any result is registered.
// One item per cycle unless the result side stalls; state updates in one step.
// Stalls on the result side back up through the input register only.
// Reset (rst_n low, synchronous): idle, card released, timeout 500, poll limit 10.
// No clearing pass; the block takes items the cycle after reset drops.
module sd_spi_command_transaction (
  input  logic                               clk,
  input  logic                               rst_n,
  sdsc_in_if.sink                            in_ch,
  sdsc_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [sdsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sdsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // adv: result register can take a new value this cycle
  logic                adv;
  logic                item_vld;
  logic                fire;
  sdsc_pkg::in_item_t  item;
  sdsc_pkg::step_res_t res;

  // input register; refills in the same cycle it drains
  sdsc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .adv      (adv),
    .item_vld (item_vld),
    .item     (item)
  );

  // a held item is stepped whenever its result (if any) has room
  assign fire = item_vld && adv;

  // sequencer: phases dummy, ready wait, packet, stuff byte, R1 poll
  sdsc_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  // result register toward the sink; ticks and ignored items leave it untouched
  sdsc_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .res    (res),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/sdsc_checker.sv =====
// Port-level checks for the command engine, bound to the top level.
`include "sd_spi_command_transaction_macros.svh"

module sdsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] mosi_byte,
  input logic       card_select,
  input logic [7:0] response
);

  `SDSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(mosi_byte) && $stable(response) && $stable(card_select), "result changed while stalled")

  `SDSC_ASSERT_NOW(a_done_mosi, clk, rst_n, out_valid && out_kind, mosi_byte == 8'd0, "finished result with nonzero mosi byte")

  `SDSC_ASSERT_NOW(a_tx_fields, clk, rst_n, out_valid && !out_kind, response == 8'd0 && card_select == 1'b0, "transmit result with response or card released")

  `SDSC_ASSERT_NOW(a_done_sel, clk, rst_n, out_valid && out_kind, card_select == 1'b0, "finished result with card released")

endmodule

bind sd_spi_command_transaction sdsc_checker u_sdsc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kind    (out_ch.out_kind),
  .mosi_byte   (out_ch.mosi_byte),
  .card_select (out_ch.card_select),
  .response    (out_ch.response)
);

// ===== verif/sd_spi_command_transaction_tb.sv =====
// Testbench for the SD SPI-mode command engine: card emulation, prediction and result checks.
`timescale 1ns / 100ps

module sd_spi_command_transaction_tb;

  // Spare cmd code; the engine must drop it without a result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Cycles with no transfer on either channel before the run is called hung.
  localparam int STALL_LIMIT = 2000;
  // Keep the log short when things go badly wrong.
  localparam int PRINT_CAP = 60;
  // Input transfers per random phase.
  localparam int PHASE_ITEMS = 250;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [sdsc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sdsc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  sdsc_in_if  in_ch ();
  sdsc_out_if out_ch ();

  sd_spi_command_transaction dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Engine shadow: register copies and sequencer state, at reset values.
  // ---------------------------------------------------------------------------
  logic [15:0] tmo_cfg  = sdsc_pkg::READY_TIMEOUT_RST;
  logic [7:0]  poll_cfg = sdsc_pkg::POLL_LIMIT_RST;

  sdsc_pkg::phase_t ph         = sdsc_pkg::PH_IDLE;
  logic [7:0]  cur_cmd         = 8'h00;
  logic [31:0] arg_q           = 32'h0;
  logic        app_prefix      = 1'b0;  // CMD55 still to go out ahead of cur_cmd
  logic [2:0]  pkt_idx         = 3'd0;
  logic [15:0] ticks_remaining = 16'd0;
  logic [7:0]  polls_remaining = 8'd0;
  logic        cs_level        = 1'b1;

  sdsc_pkg::res_item_t awaited[$];  // engine results still to be seen on out_ch

  int mismatches    = 0;
  int items_in      = 0;
  int results_out   = 0;
  int finished_cmds = 0;
  int timeouts_hit  = 0;
  int noise_pct     = 0;  // odds of a stray item inside a command
  bit calm          = 1'b0;  // no idling on either side while set

  // ---------------------------------------------------------------------------
  // Clock, result-side ready, watchdog.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side stalls with odds of about 38 in 100 unless the calm stretch is on.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 38);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TIMEOUT: no transfer in %0d cycles, %0d results outstanding",
             STALL_LIMIT, awaited.size());
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor helpers. Each one that builds a result sees cs_level as it
  // stands after the state change, same as the engine.
  // ---------------------------------------------------------------------------
  function automatic sdsc_pkg::res_item_t byte_out(input logic [7:0] b);
    sdsc_pkg::res_item_t r;
    r.out_kind    = 1'b0;
    r.mosi_byte   = b;
    r.card_select = cs_level;
    r.response    = 8'h00;
    return r;
  endfunction

  function automatic logic [7:0] cmd_now();
    return app_prefix ? sdsc_pkg::CMD55_BYTE : cur_cmd;
  endfunction

  // Packet byte: command, argument MSB first, then CRC.
  function automatic logic [7:0] pkt_byte(input logic [2:0] idx);
    logic [7:0]  c;
    logic [31:0] a;
    c = cmd_now();
    a = app_prefix ? 32'h0 : arg_q;
    case (idx)
      3'd0: return c;
      3'd1: return a[31:24];
      3'd2: return a[23:16];
      3'd3: return a[15:8];
      3'd4: return a[7:0];
      default: begin
        if (c == sdsc_pkg::CMD0_BYTE) return sdsc_pkg::CRC_CMD0;
        if (c == sdsc_pkg::CMD8_BYTE) return sdsc_pkg::CRC_CMD8;
        return sdsc_pkg::CRC_OTHER;
      end
    endcase
  endfunction

  // CS toggle is shorter than a byte, so the first byte already shows select.
  function automatic sdsc_pkg::res_item_t open_command();
    cs_level        = 1'b0;
    ticks_remaining = tmo_cfg;
    ph              = sdsc_pkg::PH_DUMMY;
    return byte_out(sdsc_pkg::BYTE_IDLE);
  endfunction

  function automatic sdsc_pkg::res_item_t open_poll();
    polls_remaining = (poll_cfg != 8'd0) ? poll_cfg : 8'd1;
    ph              = sdsc_pkg::PH_POLL;
    return byte_out(sdsc_pkg::BYTE_IDLE);
  endfunction

  // A good CMD55 answer (0 or 1) rolls straight into the real command.
  function automatic sdsc_pkg::res_item_t close_command(input logic [7:0] r1);
    sdsc_pkg::res_item_t r;
    if (app_prefix) begin
      app_prefix = 1'b0;
      if (r1 <= 8'd1) return open_command();
    end
    ph            = sdsc_pkg::PH_IDLE;
    pkt_idx       = 3'd0;
    r.out_kind    = 1'b1;
    r.mosi_byte   = 8'h00;
    r.card_select = cs_level;
    r.response    = r1;
    return r;
  endfunction

  // One accepted input transfer: advance the shadow, queue any result.
  task automatic engine_step(input sdsc_pkg::in_item_t it);
    sdsc_pkg::res_item_t r;
    bit                  got;
    got = 1'b1;
    case (it.cmd)
      sdsc_pkg::CMD_START: begin
        if (ph != sdsc_pkg::PH_IDLE) begin
          got = 1'b0;  // busy, start dropped
        end else begin
          cur_cmd    = {1'b0, it.command_byte[6:0]};
          app_prefix = it.command_byte[7];
          arg_q      = it.argument;
          pkt_idx    = 3'd0;
          r          = open_command();
        end
      end
      sdsc_pkg::CMD_TICK: begin
        if ((ph == sdsc_pkg::PH_DUMMY || ph == sdsc_pkg::PH_READY) &&
            ticks_remaining != 16'd0)
          ticks_remaining--;
        got = 1'b0;
      end
      sdsc_pkg::CMD_BYTE: begin
        case (ph)
          sdsc_pkg::PH_DUMMY: begin
            ph = sdsc_pkg::PH_READY;
            r  = byte_out(sdsc_pkg::BYTE_IDLE);
          end
          sdsc_pkg::PH_READY: begin
            if (it.miso_byte == sdsc_pkg::BYTE_IDLE) begin
              pkt_idx = 3'd0;
              ph      = sdsc_pkg::PH_SEND;
              r       = byte_out(pkt_byte(3'd0));
            end else if (ticks_remaining == 16'd0) begin
              timeouts_hit++;
              r = close_command(sdsc_pkg::BYTE_IDLE);
            end else begin
              r = byte_out(sdsc_pkg::BYTE_IDLE);
            end
          end
          sdsc_pkg::PH_SEND: begin
            pkt_idx = pkt_idx + 3'd1;
            if (pkt_idx <= sdsc_pkg::LAST_PKT_IDX) begin
              r = byte_out(pkt_byte(pkt_idx));
            end else begin
              pkt_idx = 3'd0;
              if (cmd_now() == sdsc_pkg::CMD12_BYTE) begin
                ph = sdsc_pkg::PH_STUFF;
                r  = byte_out(sdsc_pkg::BYTE_IDLE);
              end else begin
                r = open_poll();
              end
            end
          end
          sdsc_pkg::PH_STUFF: r = open_poll();
          sdsc_pkg::PH_POLL: begin
            if (polls_remaining != 8'd0) polls_remaining--;
            if (it.miso_byte[7] && polls_remaining != 8'd0)
              r = byte_out(sdsc_pkg::BYTE_IDLE);
            else
              r = close_command(it.miso_byte);
          end
          default: got = 1'b0;  // byte while idle
        endcase
      end
      default: got = 1'b0;  // spare cmd code
    endcase
    if (got) begin
      awaited.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every out_ch transfer against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : score
    sdsc_pkg::res_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_out++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: kind=%0b mosi=%02h cs=%0b r1=%02h",
                                  out_ch.out_kind, out_ch.mosi_byte, out_ch.card_select,
                                  out_ch.response));
      end else begin
        want = awaited.pop_front();
        if (want.out_kind) finished_cmds++;
        if (out_ch.out_kind !== want.out_kind)
          report_mismatch($sformatf("out_kind got %0b want %0b", out_ch.out_kind,
                                    want.out_kind));
        if (out_ch.mosi_byte !== want.mosi_byte)
          report_mismatch($sformatf("mosi_byte got %02h want %02h", out_ch.mosi_byte,
                                    want.mosi_byte));
        if (out_ch.card_select !== want.card_select)
          report_mismatch($sformatf("card_select got %0b want %0b", out_ch.card_select,
                                    want.card_select));
        if (out_ch.response !== want.response)
          report_mismatch($sformatf("response got %02h want %02h", out_ch.response,
                                    want.response));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------
  function automatic sdsc_pkg::in_item_t rand_item(input logic [1:0] c);
    sdsc_pkg::in_item_t it;
    it.cmd          = c;
    it.command_byte = 8'($urandom);
    it.argument     = $urandom;
    it.miso_byte    = 8'($urandom);
    return it;
  endfunction

  // One input transfer. valid only drops for an idle gap, never between
  // back-to-back transfers.
  task automatic send_item(input sdsc_pkg::in_item_t it);
    if (!calm && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 38) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= it.cmd;
    in_ch.command_byte <= it.command_byte;
    in_ch.argument     <= it.argument;
    in_ch.miso_byte    <= it.miso_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_in++;
    engine_step(it);
  endtask

  // Drain: all predicted results in, then let the pipeline go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sdsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == sdsc_pkg::REG_READY_TIMEOUT)
      tmo_cfg = val;
    else
      poll_cfg = val[7:0];
  endtask

  // Card side of one command, driven off the shadow phase.
  //   ticks_n: ticks sent at the start of each ready wait
  //   busy_n:  non-0xFF bytes after them before the card goes ready
  //   hold_n:  polls answered with bit 7 set before the real R1
  //   r55/r1:  R1 for the CMD55 prefix and for the command itself
  task automatic card_command(input logic [7:0] cb, input logic [31:0] arg,
                              input int ticks_n, input int busy_n, input int hold_n,
                              input logic [7:0] r55, input logic [7:0] r1);
    sdsc_pkg::in_item_t it;
    int                 tick_left;
    int                 busy_left;
    int                 hold_left;
    tick_left = 0;
    busy_left = 0;
    hold_left = 0;
    it = rand_item(sdsc_pkg::CMD_START);
    it.command_byte = cb;
    it.argument     = arg;
    send_item(it);
    while (ph != sdsc_pkg::PH_IDLE) begin
      if ($urandom_range(99) < noise_pct) begin
        // stray traffic: start while busy, spare code, or a tick
        case ($urandom_range(0, 3))
          0, 1:    send_item(rand_item(sdsc_pkg::CMD_START));
          2:       send_item(rand_item(CMD_UNUSED));
          default: send_item(rand_item(sdsc_pkg::CMD_TICK));
        endcase
      end else begin
        it = rand_item(sdsc_pkg::CMD_BYTE);
        case (ph)
          sdsc_pkg::PH_DUMMY: begin
            // new ready wait (CMD55 or the command proper)
            tick_left = ticks_n;
            busy_left = busy_n;
            hold_left = hold_n;
          end
          sdsc_pkg::PH_READY: begin
            if (tick_left > 0) begin
              it.cmd = sdsc_pkg::CMD_TICK;
              tick_left--;
            end else if (busy_left > 0) begin
              it.miso_byte = 8'($urandom_range(0, 254));
              busy_left--;
            end else begin
              it.miso_byte = sdsc_pkg::BYTE_IDLE;
            end
          end
          sdsc_pkg::PH_POLL: begin
            if (hold_left > 0) begin
              it.miso_byte[7] = 1'b1;
              hold_left--;
            end else begin
              it.miso_byte = app_prefix ? r55 : r1;
            end
          end
          default: ;  // packet and stuff bytes: card sends anything
        endcase
        send_item(it);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset register values; CRC choice for CMD0, CMD8 and a plain command.
  task automatic test_defaults_and_crc();
    card_command(sdsc_pkg::CMD0_BYTE, 32'h0, 0, 0, 0, 8'h00, 8'h01);
    card_command(sdsc_pkg::CMD8_BYTE, 32'h0000_01AA, 0, 2, 1, 8'h00, 8'h01);
    card_command(8'h51, 32'hFFFF_FFFF, 1, 3, 2, 8'h00, 8'h00);
  endtask

  // CMD12 gets one stuff byte before polling.
  task automatic test_stop_stuff();
    card_command(sdsc_pkg::CMD12_BYTE, 32'h0, 0, 1, 1, 8'h00, 8'h7F);
  endtask

  // Application commands: CMD55 answered 1, answered 0, and rejected early.
  task automatic test_app_prefix();
    card_command(8'hE9, 32'h40FF_8000, 0, 1, 1, 8'h01, 8'h00);
    card_command(8'hC0, 32'h1234_5678, 0, 0, 0, 8'h00, 8'h01);
    card_command(8'hCD, 32'h0, 0, 0, 0, 8'h05, 8'h00);
  endtask

  // Ready wait running out, in the prefix too, with zero and max timeout.
  task automatic test_ready_timeout();
    write_reg(sdsc_pkg::REG_READY_TIMEOUT, 16'd2);
    card_command(8'h51, $urandom, 3, 1, 0, 8'h00, 8'h00);
    card_command(8'hE9, $urandom, 2, 1, 0, 8'h00, 8'h00);
    card_command(8'h58, $urandom, 1, 2, 0, 8'h00, 8'h00);  // one tick short
    write_reg(sdsc_pkg::REG_READY_TIMEOUT, 16'd0);
    card_command(sdsc_pkg::CMD0_BYTE, 32'h0, 0, 1, 0, 8'h00, 8'h01);
    write_reg(sdsc_pkg::REG_READY_TIMEOUT, 16'hFFFF);
    card_command(8'h51, $urandom, 4, 2, 0, 8'h00, 8'h00);
  endtask

  // Poll limit of 1, 0 (acts as 1) and 255; card stays busy past the short ones.
  task automatic test_poll_limit();
    write_reg(sdsc_pkg::REG_POLL_LIMIT, 16'd1);
    card_command(8'h51, $urandom, 0, 0, 2, 8'h00, 8'h00);
    write_reg(sdsc_pkg::REG_POLL_LIMIT, 16'd0);
    card_command(8'h51, $urandom, 0, 0, 2, 8'h00, 8'h00);
    write_reg(sdsc_pkg::REG_POLL_LIMIT, 16'd255);
    card_command(8'h51, $urandom, 0, 0, 6, 8'h00, 8'h02);
  endtask

  // Idle byte, idle tick, spare code, then a command peppered with strays.
  task automatic test_ignored_items();
    send_item(rand_item(sdsc_pkg::CMD_BYTE));
    send_item(rand_item(sdsc_pkg::CMD_TICK));
    send_item(rand_item(CMD_UNUSED));
    noise_pct = 50;
    card_command(8'h51, $urandom, 1, 2, 2, 8'h00, 8'h00);
    noise_pct = 0;
  endtask

  task automatic random_command();
    logic [7:0]  cb;
    logic [31:0] arg;
    logic [7:0]  r55;
    logic [7:0]  r1;
    int          hold_n;
    case ($urandom_range(0, 5))
      0:       cb = sdsc_pkg::CMD0_BYTE;
      1:       cb = sdsc_pkg::CMD8_BYTE;
      2:       cb = sdsc_pkg::CMD12_BYTE;
      3:       cb = sdsc_pkg::CMD55_BYTE;
      default: cb = 8'($urandom_range(0, 127));
    endcase
    if ($urandom_range(99) < 30) cb[7] = 1'b1;
    case ($urandom_range(0, 9))
      0:       arg = 32'h0;
      1:       arg = 32'hFFFF_FFFF;
      default: arg = $urandom;
    endcase
    r55    = ($urandom_range(99) < 75) ? 8'($urandom_range(0, 1)) : 8'($urandom);
    r1     = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 127)) : 8'($urandom);
    hold_n = ($urandom_range(99) < 85) ? $urandom_range(0, 3) : $urandom_range(4, 12);
    // occasional stray traffic while the engine sits idle
    if ($urandom_range(99) < 8) send_item(rand_item(sdsc_pkg::CMD_BYTE));
    if ($urandom_range(99) < 5) send_item(rand_item(sdsc_pkg::CMD_TICK));
    card_command(cb, arg, $urandom_range(0, 4), $urandom_range(0, 4), hold_n, r55, r1);
  endtask

  // Five phases of random commands, each under its own register setting.
  task automatic test_random_traffic();
    logic [15:0] tmo_set  [5];
    logic [7:0]  poll_set [5];
    int          target;
    tmo_set  = '{16'd500, 16'd1, 16'hFFFF, 16'd3, 16'($urandom_range(1, 65535))};
    poll_set = '{8'd10, 8'd1, 8'd255, 8'd2, 8'($urandom_range(1, 255))};
    noise_pct = 3;
    for (int p = 0; p < 5; p++) begin
      write_reg(sdsc_pkg::REG_READY_TIMEOUT, tmo_set[p]);
      write_reg(sdsc_pkg::REG_POLL_LIMIT, {8'h00, poll_set[p]});
      calm = (p == 2);  // long stretch with both sides always ready
      target = items_in + PHASE_ITEMS;
      while (items_in < target) random_command();
    end
    calm = 1'b0;
    noise_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= sdsc_pkg::REG_READY_TIMEOUT;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.cmd          <= sdsc_pkg::CMD_TICK;
    in_ch.command_byte <= 8'h00;
    in_ch.argument     <= 32'h0;
    in_ch.miso_byte    <= 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_defaults_and_crc();
    test_stop_stuff();
    test_app_prefix();
    test_ready_timeout();
    test_poll_limit();
    test_ignored_items();
    test_random_traffic();

    settle();
    repeat (8) @(posedge clk);
    if (awaited.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", awaited.size()));

    $display("Run: %0d item transfers in, %0d result transfers out, %0d mismatching fields.",
             items_in, results_out, mismatches);
    $display("Commands finished: %0d, of which %0d ended on a ready timeout.",
             finished_cmds, timeouts_hit);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sdsc_pkg.sv
rtl/sdsc_in_if.sv
rtl/sdsc_out_if.sv
rtl/sdsc_in_stage.sv
rtl/sdsc_step.sv
rtl/sdsc_out_reg.sv
rtl/sd_spi_command_transaction.sv
rtl/sdsc_checker.sv
verif/sd_spi_command_transaction_tb.sv
